### design/file_directory_allocator_assert.svh
// Assertion macros for the directory allocator.
`ifndef FILE_DIRECTORY_ALLOCATOR_ASSERT_SVH
`define FILE_DIRECTORY_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define FDA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FDA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDA_ASSERT(label, clk, rst, prop, msg)
`define FDA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### design/fda_pkg.sv
//------------------------------------------------------------------------------
// fda_pkg
// Shared codes and types for the directory allocator.
//------------------------------------------------------------------------------
`default_nettype none
package fda_pkg;
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_FORMAT = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EXISTS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // slot index width, wide enough for the largest slot count
  localparam int SLOT_IDX_W = 10;

  // operation applied by the cells when a sweep ends
  typedef enum logic [1:0] {
    OP_SCAN,
    OP_WRITE,
    OP_FREE,
    OP_CLEAR
  } cell_op_t;

  // control broadcast to the row
  typedef struct packed {
    logic                  go;
    cell_op_t              op;
    logic [SLOT_IDX_W-1:0] target;
  } cell_ctl_t;

  // sweep token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } slot_tok_t;
endpackage
`default_nettype wire

### design/file_directory_allocator.sv
//------------------------------------------------------------------------------
// file_directory_allocator
// Name directory with first-fit slot allocation over a row of slot cells.
//------------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command and name_char. Append
//   words only extend the pending name and give no result. Create, delete,
//   lookup and format each give one result word on out_valid/out_ready.
//   A directory command sends a token down the row of SLOT_COUNT cells, one
//   cell per cycle; the update and the result register follow when it leaves
//   the last cell. A further directory command is taken only once the sweep
//   is over and the receiver has taken the last result. Appends are taken
//   every cycle outside a sweep.
//   While a result waits in the output register the block takes appends but
//   holds any further directory command.
//   Reset clears all used marks, names, the pending buffer and the output.
//   Unused command codes are taken and dropped.
//------------------------------------------------------------------------------
`default_nettype none
`include "file_directory_allocator_assert.svh"
module file_directory_allocator
  import fda_pkg::*;
#(
  parameter int SLOT_COUNT  = 90,
  parameter int FIRST_BLOCK = 10,
  parameter int NAME_CHARS  = 31
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [7:0] name_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [6:0]      block_number
);
  localparam int LenW = $clog2(NAME_CHARS + 1);

  logic [NAME_CHARS*8-1:0] pending;
  logic [LenW-1:0]         plen;
  logic                    busy;      // sweep in progress
  logic [2:0]              cmd_hold;

  slot_tok_t               tok_chain [SLOT_COUNT+1];
  slot_tok_t               tok_end;
  cell_ctl_t               ctl;
  logic [6:0]              blk_hit, blk_free;

  logic is_dir, take;
  assign is_dir   = command inside {CMD_CREATE, CMD_DELETE, CMD_LOOKUP, CMD_FORMAT};
  assign in_ready = !busy && (!is_dir || !out_valid);
  assign take     = in_valid && in_ready;

  // launch the token into the first cell when a directory word is taken
  assign tok_chain[0] = '{valid: take && is_dir, default: '0};
  assign tok_end      = tok_chain[SLOT_COUNT];

  assign blk_hit  = 7'(FIRST_BLOCK + int'(tok_end.hit_idx));
  assign blk_free = 7'(FIRST_BLOCK + int'(tok_end.free_idx));

  always_comb begin
    ctl.go     = tok_end.valid;
    ctl.target = tok_end.hit_idx;
    case (cmd_hold)
      CMD_CREATE: begin
        ctl.op     = (tok_end.hit || !tok_end.free) ? OP_SCAN : OP_WRITE;
        ctl.target = tok_end.free_idx;
      end
      CMD_DELETE: ctl.op = tok_end.hit ? OP_FREE : OP_SCAN;
      CMD_FORMAT: ctl.op = OP_CLEAR;
      default:    ctl.op = OP_SCAN;
    endcase
  end

  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_cell
    fda_cell #(.NameChars(NAME_CHARS), .SlotId(s)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .name(pending),
      .tok_in(tok_chain[s]), .tok_out(tok_chain[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      plen         <= '0;
      busy         <= 1'b0;
      cmd_hold     <= CMD_APPEND;
      out_valid    <= 1'b0;
      status       <= ST_DONE;
      block_number <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        if (command == CMD_APPEND) begin
          if (name_char != 8'd0 && int'(plen) < NAME_CHARS) begin
            pending[int'(plen)*8 +: 8] <= name_char;
            plen <= plen + LenW'(1);
          end
        end else if (is_dir) begin
          busy     <= 1'b1;
          cmd_hold <= command;
        end
      end
      if (tok_end.valid) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        pending   <= '0;
        plen      <= '0;
        case (cmd_hold)
          CMD_CREATE: begin
            if (tok_end.hit) begin
              status <= ST_EXISTS; block_number <= '0;
            end else if (!tok_end.free) begin
              status <= ST_FULL; block_number <= '0;
            end else begin
              status <= ST_DONE; block_number <= blk_free;
            end
          end
          CMD_DELETE, CMD_LOOKUP: begin
            if (tok_end.hit) begin
              status <= ST_DONE; block_number <= blk_hit;
            end else begin
              status <= ST_NOTFOUND; block_number <= '0;
            end
          end
          default: begin
            status <= ST_DONE; block_number <= '0;
          end
        endcase
      end
    end
  end

  `FDA_ASSERT(a_no_take_busy, clk, rst, busy |-> !in_ready, "word taken while busy")
  `FDA_ASSERT(a_sweep_in_busy, clk, rst, tok_end.valid |-> busy, "token outside a command")
  `FDA_ASSERT(a_out_not_busy, clk, rst, !(out_valid && busy), "sweep with a result waiting")
  `FDA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_number), "result changed while waiting")
endmodule
`default_nettype wire

### design/fda_cell.sv
//------------------------------------------------------------------------------
// fda_cell
// One directory slot: used mark and stored name. Registers the sweep token
// from its left neighbor each cycle, adds its own match and free state, and
// hands it to the right.
//------------------------------------------------------------------------------
`default_nettype none
module fda_cell
  import fda_pkg::*;
#(
  parameter int NameChars = 31,
  parameter int SlotId    = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctl_t              ctl,
  input  wire logic [NameChars*8-1:0] name,
  input  wire slot_tok_t              tok_in,
  output slot_tok_t                   tok_out
);
  logic                   used;
  logic [NameChars*8-1:0] stored;
  logic                   match;
  logic                   sel;

  assign match = used && (stored == name);
  assign sel   = (ctl.target == SLOT_IDX_W'(SlotId));

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      stored  <= '0;
      tok_out <= '0;
    end else begin
      // keep the first hit and the first free slot seen so far
      tok_out.valid    <= tok_in.valid;
      tok_out.hit      <= tok_in.hit || match;
      tok_out.hit_idx  <= tok_in.hit ? tok_in.hit_idx : SLOT_IDX_W'(SlotId);
      tok_out.free     <= tok_in.free || !used;
      tok_out.free_idx <= tok_in.free ? tok_in.free_idx : SLOT_IDX_W'(SlotId);
      if (ctl.go) begin
        case (ctl.op)
          OP_WRITE: if (sel) begin
            used   <= 1'b1;
            stored <= name;
          end
          OP_FREE: if (sel) begin
            used   <= 1'b0;
            stored <= '0;
          end
          OP_CLEAR: begin
            used   <= 1'b0;
            stored <= '0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire
